FILE: hdl/lzrd_pkg.sv
// ============================================================================
// lzrd_pkg: shared types and constants for the LZSS ring decompressor
// Holds the controller states, the command and status bundles exchanged by the
// controller and the datapath, and the token format constants.
// ============================================================================
package lzrd_pkg;

   localparam int RING_DEPTH_DEF = 8192;

   // Token format.
   localparam int TOK_W      = 17;
   localparam int CNT_W      = 5;
   localparam int OFFSET_W   = 13;
   localparam int LEN_W      = 4;
   localparam int LIT_BITS   = 9;
   localparam int END_BITS   = 14;
   localparam int MATCH_BITS = 18;
   localparam int MIN_MATCH  = 3;
   localparam int BYTE_W     = 8;
   localparam int BIT_LEFT_W = 4;
   localparam int REMAIN_W   = 5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BITS,
      ST_LIT,
      ST_RD,
      ST_WR,
      ST_END
   } state_type;

   typedef struct packed {
      logic load_byte;
      logic step_bit;
      logic clr_wr;
      logic lit_emit;
      logic rd_issue;
      logic copy_emit;
      logic end_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic lit_done;
      logic end_hit;
      logic match_done;
      logic last_bit;
      logic more_bits;
      logic out_free;
      logic copy_last;
      logic clr_last;
   } dp_stat_type;

endpackage

FILE: hdl/lzrd_ctrl.sv
// ============================================================================
// lzrd_ctrl: sequencing controller for the LZSS ring decompressor
// Walks the bits of each request, steers literal, copy and end-marker
// emission, and runs the ring clearing pass after reset.
// ============================================================================
module lzrd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lzrd_pkg::dp_stat_type stat,
   output lzrd_pkg::ctrl_cmd_type cmd
);
   import lzrd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_byte = 1'b1;
               state_in      = ST_BITS;
            end
         end
         ST_BITS: begin
            cmd.step_bit = 1'b1;
            priority if (stat.lit_done) begin
               state_in = ST_LIT;
            end else if (stat.end_hit) begin
               state_in = ST_END;
            end else if (stat.match_done) begin
               state_in = ST_RD;
            end else if (stat.last_bit) begin
               state_in = ST_IDLE;
            end
         end
         ST_LIT: begin
            if (stat.out_free) begin
               cmd.lit_emit = 1'b1;
               state_in     = stat.more_bits ? ST_BITS : ST_IDLE;
            end
         end
         ST_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_WR;
         end
         ST_WR: begin
            if (stat.out_free) begin
               cmd.copy_emit = 1'b1;
               if (stat.copy_last) begin
                  state_in = stat.more_bits ? ST_BITS : ST_IDLE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_END: begin
            // The rest of the byte is dropped after the end marker.
            if (stat.out_free) begin
               cmd.end_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/lzrd_dpath.sv
// ============================================================================
// lzrd_dpath: datapath for the LZSS ring decompressor
// Token shift register, ring window memory, write pointer, copy address and
// length counters, and the response output register.
// ============================================================================
module lzrd_dpath #(
   parameter int RING_DEPTH = lzrd_pkg::RING_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_in_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_stream_end,
   output logic                   rsp_last_of_run,
   input  lzrd_pkg::ctrl_cmd_type cmd,
   output lzrd_pkg::dp_stat_type  stat
);
   import lzrd_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);

   logic [BYTE_W-1:0]     ring [RING_DEPTH];

   logic [BYTE_W-1:0]     shift_ff;
   logic [BIT_LEFT_W-1:0] bits_left_ff;
   logic [TOK_W-1:0]      tok_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [AW-1:0]         wp_ff;
   logic [AW-1:0]         rd_addr_ff;
   logic [REMAIN_W-1:0]   remain_ff;
   logic [BYTE_W-1:0]     pend_ff;
   logic [AW-1:0]         clr_ff;
   logic [BYTE_W-1:0]     rdata_ff;
   logic                  out_valid_ff;
   logic [BYTE_W-1:0]     out_byte_ff;
   logic                  out_end_ff;
   logic                  out_last_ff;

   logic [TOK_W-1:0]      new_tok;
   logic [CNT_W-1:0]      new_cnt;
   logic [CNT_W-1:0]      first_pos;
   logic                  first_bit;
   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [BYTE_W-1:0]     mem_wd;
   logic                  out_load;

   // The token so far with the next input bit appended.
   always_comb begin
      new_tok   = {tok_ff[TOK_W-2:0], shift_ff[BYTE_W-1]};
      new_cnt   = cnt_ff + CNT_W'(1);
      first_pos = new_cnt - CNT_W'(1);
      // Once the token is longer than the register, its first bit (a zero) has
      // been shifted out, so it can only be a match.
      first_bit = (new_cnt > CNT_W'(TOK_W)) ? 1'b0 : new_tok[first_pos];
   end

   always_comb begin
      stat.lit_done   = first_bit && (new_cnt >= CNT_W'(LIT_BITS));
      stat.end_hit    = !first_bit && (new_cnt == CNT_W'(END_BITS)) &&
                        (new_tok[OFFSET_W-1:0] == '0);
      stat.match_done = !first_bit && (new_cnt >= CNT_W'(MATCH_BITS));
      stat.last_bit   = (bits_left_ff == BIT_LEFT_W'(1));
      stat.more_bits  = (bits_left_ff != '0);
      stat.out_free   = !out_valid_ff || !rsp_stall;
      stat.copy_last  = (remain_ff == REMAIN_W'(1));
      stat.clr_last   = (clr_ff == AW'(RING_DEPTH - 1));
   end

   // Bit walker and token assembly.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
         tok_ff       <= '0;
         cnt_ff       <= '0;
      end else if (cmd.load_byte) begin
         bits_left_ff <= BIT_LEFT_W'(BYTE_W);
      end else if (cmd.step_bit) begin
         if (stat.end_hit) begin
            bits_left_ff <= '0;
         end else begin
            bits_left_ff <= bits_left_ff - BIT_LEFT_W'(1);
         end
         if (stat.lit_done || stat.end_hit || stat.match_done) begin
            tok_ff <= '0;
            cnt_ff <= '0;
         end else begin
            tok_ff <= new_tok;
            cnt_ff <= new_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         shift_ff <= req_in_byte;
      end else if (cmd.step_bit) begin
         shift_ff <= {shift_ff[BYTE_W-2:0], 1'b0};
      end
   end

   // Literal value and copy descriptor captured when a token completes.
   always_ff @(posedge clock) begin
      if (cmd.step_bit && stat.lit_done) begin
         pend_ff <= new_tok[BYTE_W-1:0];
      end
      if (cmd.step_bit && stat.match_done) begin
         rd_addr_ff <= AW'(new_tok[TOK_W-1:LEN_W]);
         remain_ff  <= REMAIN_W'(new_tok[LEN_W-1:0]) + REMAIN_W'(MIN_MATCH);
      end else if (cmd.copy_emit) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
         remain_ff  <= remain_ff - REMAIN_W'(1);
      end
   end

   // Write pointer and clearing sweep counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= AW'(1);
         clr_ff <= '0;
      end else begin
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (cmd.step_bit && stat.end_hit) begin
            wp_ff <= AW'(1);
         end else if (cmd.lit_emit || cmd.copy_emit) begin
            wp_ff <= wp_ff + AW'(1);
         end
      end
   end

   // Ring window: one write port, one registered read port.
   always_comb begin
      mem_we = cmd.clr_wr || cmd.lit_emit || cmd.copy_emit;
      mem_wa = cmd.clr_wr ? clr_ff : wp_ff;
      priority if (cmd.clr_wr) begin
         mem_wd = '0;
      end else if (cmd.lit_emit) begin
         mem_wd = pend_ff;
      end else begin
         mem_wd = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[mem_wa] <= mem_wd;
      end
      if (cmd.rd_issue) begin
         rdata_ff <= ring[rd_addr_ff];
      end
   end

   // Response register.
   assign out_load = cmd.lit_emit || cmd.copy_emit || cmd.end_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         priority if (cmd.lit_emit) begin
            out_byte_ff <= pend_ff;
            out_end_ff  <= 1'b0;
            out_last_ff <= 1'b1;
         end else if (cmd.copy_emit) begin
            out_byte_ff <= rdata_ff;
            out_end_ff  <= 1'b0;
            out_last_ff <= stat.copy_last;
         end else begin
            out_byte_ff <= '0;
            out_end_ff  <= 1'b1;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_stream_end  = out_end_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

FILE: hdl/lzss_ring_decompressor.sv
// ============================================================================
// lzss_ring_decompressor: LZSS decompressor over a ring window
// Each compressed request byte is taken and then decoded one bit per cycle,
// pausing while a completed token is emitted. A literal is written to the
// ring and the response register; a match copies each byte by a registered
// ring read, then the write and response load, giving 3 to 18 responses.
// Each copied byte needs its own ring read, since the write uses the
// registered read data. A stalled response register holds the controller.
// After reset the ring is swept to zero, one entry per cycle, and no request
// is taken until the sweep is done. The ring contents persist across streams.
// ============================================================================
module lzss_ring_decompressor #(
   parameter int RING_DEPTH = lzrd_pkg::RING_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_stream_end,
   output logic       rsp_last_of_run
);
   import lzrd_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   lzrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzrd_dpath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_stream_end  (rsp_stream_end),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

FILE: hdl/lzrd_checker.sv
// ============================================================================
// lzrd_checker: port-level checks for the LZSS ring decompressor
// Watches the request and response channels of the top level over time.
// ============================================================================
module lzrd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_stream_end,
   input logic       rsp_last_of_run
);

   // A stalled response must hold its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_stream_end) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // The end marker response carries a zero byte and closes its run.
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_last_of_run && (rsp_out_byte == 8'd0))
      else $error("malformed end marker response");

   // The ring sweep keeps requests out right after reset.
   a_reset_stall: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not held off after reset");

   // Each request byte is decoded bit by bit, so no request can follow at once.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted in consecutive cycles");

   // An accepted request byte must carry no unknown bits.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> !$isunknown(req_in_byte))
      else $error("accepted request byte is unknown");

endmodule

bind lzss_ring_decompressor lzrd_checker u_lzrd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_in_byte     (req_in_byte),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_stream_end  (rsp_stream_end),
   .rsp_last_of_run (rsp_last_of_run)
);

FILE: tb/sv/lzss_ring_decompressor_test.sv
// ============================================================================
// lzss_ring_decompressor_test: self-checking bench for the LZSS ring decoder
// Builds compressed streams bit by bit (literals, window copies, end markers),
// feeds them to the block with random idle cycles and response stalls, and
// checks every response against a bit-level decoder with its own ring window.
// ============================================================================
`timescale 1ns / 100ps

module lzss_ring_decompressor_test;
   import lzrd_pkg::*;

   localparam int IDLE_LIMIT  = 50000;
   localparam int ITEM_TARGET = 305;
   localparam int SETTLE      = 64;

   // Decodes accepted request bytes into the responses the block must give.
   class window_decoder_type;
      typedef struct {
         logic [7:0] out_byte;
         logic       stream_end;
         logic       last_of_run;
      } decoded_rsp_type;

      logic [7:0]      ring [RING_DEPTH_DEF];
      logic [12:0]     wr_ptr;
      logic [16:0]     tok;
      int unsigned     tok_n;
      logic            lead;
      decoded_rsp_type expected_q[$];
      int unsigned     mismatches;

      function new();
         foreach (ring[i]) ring[i] = '0;
         wr_ptr = 13'd1;
         tok = '0;
         tok_n = 0;
         lead = 1'b0;
         mismatches = 0;
      endfunction

      function void push_rsp(logic [7:0] value, logic is_end);
         decoded_rsp_type r;
         r.out_byte = value;
         r.stream_end = is_end;
         r.last_of_run = 1'b0;
         expected_q.push_back(r);
      endfunction

      function void store(logic [7:0] value);
         ring[wr_ptr] = value;
         wr_ptr = wr_ptr + 13'd1;
      endfunction

      function void note_request(logic [7:0] in_byte);
         int unsigned     before_n;
         int              b;
         int              k;
         int unsigned     run_len;
         logic [12:0]     offset;
         logic [12:0]     idx;
         logic [7:0]      value;
         decoded_rsp_type tail;
         before_n = expected_q.size();
         for (b = 7; b >= 0; b--) begin
            tok = {tok[15:0], in_byte[b]};
            tok_n++;
            if (tok_n == 1) lead = in_byte[b];
            if (lead) begin
               if (tok_n == LIT_BITS) begin
                  push_rsp(tok[7:0], 1'b0);
                  store(tok[7:0]);
                  tok = '0;
                  tok_n = 0;
               end
            end else if (tok_n == END_BITS && tok[12:0] == '0) begin
               // The rest of this byte is thrown away.
               push_rsp(8'h00, 1'b1);
               tok = '0;
               tok_n = 0;
               wr_ptr = 13'd1;
               break;
            end else if (tok_n == MATCH_BITS) begin
               offset = tok[16:4];
               run_len = tok[3:0] + MIN_MATCH;
               for (k = 0; k < run_len; k++) begin
                  idx = offset + 13'(k);
                  value = ring[idx];
                  push_rsp(value, 1'b0);
                  store(value);
               end
               tok = '0;
               tok_n = 0;
            end
         end
         if (expected_q.size() > before_n) begin
            tail = expected_q.pop_back();
            tail.last_of_run = 1'b1;
            expected_q.push_back(tail);
         end
      endfunction

      function void check_response(logic [7:0] out_byte, logic stream_end,
                                   logic last_of_run);
         decoded_rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: out_byte %02h", out_byte);
            mismatches++;
            return;
         end
         e = expected_q.pop_front();
         if (out_byte !== e.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", e.out_byte, out_byte);
            mismatches++;
         end
         if (stream_end !== e.stream_end) begin
            $error("stream_end: expected %0b, actual %0b", e.stream_end, stream_end);
            mismatches++;
         end
         if (last_of_run !== e.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", e.last_of_run, last_of_run);
            mismatches++;
         end
      endfunction

      function int unsigned pending_count();
         return expected_q.size();
      endfunction

      function bit token_busy();
         return tok_n != 0;
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_stream_end;
   logic       rsp_last_of_run;

   window_decoder_type board;
   bit                 quiet_span = 1'b0;
   int unsigned        items_sent = 0;
   int unsigned        idle_cycles = 0;
   bit                 bit_q[$];
   logic [12:0]        est_ptr;

   lzss_ring_decompressor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_stream_end (rsp_stream_end),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side: check accepted responses and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_out_byte, rsp_stream_end, rsp_last_of_run);
      rsp_stall <= !quiet_span && ($urandom_range(0, 99) < 8);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("lzss_ring_decompressor test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_byte(input logic [7:0] value);
      if (!quiet_span && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(value);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_count() != 0);
   endtask

   task automatic push_bits(input logic [17:0] value, input int width);
      logic [7:0] packed_byte;
      int         i;
      for (i = width - 1; i >= 0; i--) bit_q.push_back(value[i]);
      while (bit_q.size() >= 8) begin
         for (i = 7; i >= 0; i--) packed_byte[i] = bit_q.pop_front();
         send_byte(packed_byte);
      end
   endtask

   task automatic put_literal(input logic [7:0] value);
      push_bits({9'd0, 1'b1, value}, LIT_BITS);
      est_ptr = est_ptr + 13'd1;
   endtask

   task automatic put_match(input logic [12:0] offset, input logic [3:0] len);
      push_bits({1'b0, offset, len}, MATCH_BITS);
      est_ptr = est_ptr + 13'(len) + 13'(MIN_MATCH);
   endtask

   // End marker, then the leftover bits of its byte filled with junk.
   task automatic put_end(input bit fill_ones);
      push_bits(18'd0, END_BITS);
      while (bit_q.size() % 8 != 0) bit_q.push_back(fill_ones ? 1'b1 : 1'($urandom));
      push_bits(18'd0, 0);
      est_ptr = 13'd1;
   endtask

   // Zero bytes are sent until no token is open, which realigns the decoder; a run of zeros ends in an end marker.
   task automatic resync();
      while (board.token_busy()) send_byte(8'h00);
   endtask

   task automatic random_stream();
      int          tokens;
      int          j;
      int unsigned pick;
      logic [12:0] offset;
      est_ptr = board.wr_ptr;
      tokens = $urandom_range(1, 12);
      for (j = 0; j < tokens; j++) begin
         if ($urandom_range(0, 99) < 50) begin
            put_literal(8'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10) offset = 13'h1fff;
            else if (pick < 70) offset = est_ptr - 13'($urandom_range(1, 24));
            else offset = 13'($urandom_range(1, 8191));
            if (offset == '0) offset = 13'd1;
            put_match(offset, 4'($urandom_range(0, 15)));
         end
      end
      put_end(1'b0);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_byte(8'h00);
      resync();
   endtask

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: literal extremes, an overlapping copy, a copy from the top of
      // the window that wraps to entry zero, the longest copy and end markers.
      est_ptr = 13'd1;
      put_literal(8'h00);
      put_literal(8'hff);
      put_match(13'd1, 4'd0);
      put_match(13'h1fff, 4'hf);
      put_match(13'd2, 4'hf);
      put_end(1'b1);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h7f);
      send_byte(8'hff);
      resync();
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         quiet_span = items_sent >= 150 && items_sent < 230;
         if ($urandom_range(0, 99) < 85) begin
            random_stream();
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            resync();
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      quiet_span = 1'b0;

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (board.mismatches == 0 && board.pending_count() == 0)
         $display("lzss_ring_decompressor test passed");
      else
         $display("lzss_ring_decompressor test failed");
      $finish;
   end

endmodule
